>>> rtl/core/ihss_pkg.sv
// shared codes, types and byte-walk step for the image header size sniffer
package ihss_pkg;

  localparam int ByteW = 8;
  localparam int DimW  = 16;
  localparam int KindW = 2;
  localparam int PhaseW = 4;
  localparam int IdxW  = 4;

  // result kinds
  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_GIF  = 2'd1;
  localparam logic [KindW-1:0] KIND_JPEG = 2'd2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_HEAD = 4'd0;
  localparam logic [PhaseW-1:0] PH_SKIP = 4'd1;
  localparam logic [PhaseW-1:0] PH_MARK = 4'd2;
  localparam logic [PhaseW-1:0] PH_LHI  = 4'd3;
  localparam logic [PhaseW-1:0] PH_LLO  = 4'd4;
  localparam logic [PhaseW-1:0] PH_PREC = 4'd5;
  localparam logic [PhaseW-1:0] PH_HHI  = 4'd6;
  localparam logic [PhaseW-1:0] PH_HLO  = 4'd7;
  localparam logic [PhaseW-1:0] PH_WHI  = 4'd8;
  localparam logic [PhaseW-1:0] PH_WLO  = 4'd9;
  localparam logic [PhaseW-1:0] PH_DONE = 4'd10;

  // header layout
  localparam logic [IdxW-1:0] IDX_GIF_END = 4'd2;
  localparam logic [IdxW-1:0] IDX_LAST    = 4'd9;
  localparam int              HdrKeep     = 9;

  // start-of-frame marker codes
  localparam logic [ByteW-1:0] SOF0 = 8'hC0;
  localparam logic [ByteW-1:0] SOF1 = 8'hC1;
  localparam logic [ByteW-1:0] SOF9 = 8'hC9;

  localparam logic [DimW-1:0] MIN_SEG_LEN = 16'd2;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  marker;
    logic [DimW-1:0]   seglen;
    logic [DimW-1:0]   skip;
    logic [DimW-1:0]   height;
    logic [DimW-1:0]   width;
    logic              fire;
    logic [KindW-1:0]  kind;
  } walk_t;

  function automatic logic [ByteW-1:0] upcase(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= "a" && b <= "z") r = b - 8'd32;
    return r;
  endfunction

  // one byte through the marker walker; a finished walk parks in PH_DONE
  function automatic walk_t walk_step(input walk_t s, input logic [ByteW-1:0] b);
    walk_t r;
    r      = s;
    r.fire = 1'b0;
    r.kind = KIND_NONE;
    case (s.phase)
      PH_SKIP: begin
        r.skip = s.skip - 16'd1;
        if (r.skip == '0) r.phase = PH_MARK;
      end
      PH_MARK: begin
        r.marker = b;
        r.phase  = PH_LHI;
      end
      PH_LHI: begin
        r.seglen = {b, 8'h00};
        r.phase  = PH_LLO;
      end
      PH_LLO: begin
        r.seglen = {s.seglen[15:8], b};
        if (s.marker inside {SOF0, SOF1, SOF9}) begin
          r.phase = PH_PREC;
        end else if (r.seglen < MIN_SEG_LEN) begin
          r.fire  = 1'b1;
          r.phase = PH_DONE;
        end else begin
          r.skip  = r.seglen - 16'd1;
          r.phase = PH_SKIP;
        end
      end
      PH_PREC: r.phase = PH_HHI;
      PH_HHI: begin
        r.height = {b, 8'h00};
        r.phase  = PH_HLO;
      end
      PH_HLO: begin
        r.height = {s.height[15:8], b};
        r.phase  = PH_WHI;
      end
      PH_WHI: begin
        r.width = {b, 8'h00};
        r.phase = PH_WLO;
      end
      PH_WLO: begin
        r.width = {s.width[15:8], b};
        r.fire  = 1'b1;
        r.kind  = KIND_JPEG;
        r.phase = PH_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/image_header_size_sniffer.sv
// top level: gif / jfif header dimension sniffer over a byte stream
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+---------------------------
//  in      | in  | in_valid / in_stall | in_byte, last_byte
//  out     | out | out_valid/ out_stall| kind, width, height
//
// one byte is taken per cycle while in_stall is low; the result of a file leaves in the cycle
// after the byte that settles it, through a single output register
// a file's tenth byte runs up to four bytes of the marker walker at once
// rst (synchronous) returns the parser to the start of a new file
// in_stall is high only while a result sits in the output register and
// the sink stalls it; every accepted last_byte returns the parser to its start state
module image_header_size_sniffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ihss_pkg::ByteW-1:0]  in_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ihss_pkg::KindW-1:0]  kind,
  output logic [ihss_pkg::DimW-1:0]   width,
  output logic [ihss_pkg::DimW-1:0]   height
);
  import ihss_pkg::*;

  // parser state
  logic [PhaseW-1:0] phase, phase_next;
  logic [IdxW-1:0]   header_index, header_index_next;
  logic              gif_match, gif_match_next;
  logic [ByteW-1:0]  marker, marker_next;
  logic [DimW-1:0]   segment_length, segment_length_next;
  logic [DimW-1:0]   skip_count, skip_count_next;
  logic [DimW-1:0]   width_acc, width_acc_next;
  logic [DimW-1:0]   height_acc, height_acc_next;
  logic [ByteW-1:0]  hdr [HdrKeep];

  logic              in_take;
  logic              fire;
  logic [KindW-1:0]  fire_kind;
  logic [DimW-1:0]   fire_width, fire_height;
  logic              res;
  logic              jfif_match;
  logic [DimW-1:0]   app0_len;
  walk_t             cur, w0, w1, w2, w3, walked, stepped;

  // room in the output register, or it empties this cycle
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign jfif_match = (upcase(hdr[6]) == "J") && (upcase(hdr[7]) == "F") &&
                      (upcase(hdr[8]) == "I") && (upcase(in_byte) == "F");
  assign app0_len   = {hdr[4], hdr[5]};

  always_comb begin
    cur.phase  = phase;
    cur.marker = marker;
    cur.seglen = segment_length;
    cur.skip   = skip_count;
    cur.height = height_acc;
    cur.width  = width_acc;
    cur.fire   = 1'b0;
    cur.kind   = KIND_NONE;
  end

  // header expansion: walker starts in skip with app0 length - 1, then
  // consumes header bytes 6..9 (byte 9 is the one arriving now)
  always_comb begin
    w0        = cur;
    w0.phase  = PH_SKIP;
    w0.seglen = app0_len;
    w0.skip   = app0_len - 16'd1;
    w1        = walk_step(w0, hdr[6]);
    w2        = walk_step(w1, hdr[7]);
    w3        = walk_step(w2, hdr[8]);
    walked    = walk_step(w3, in_byte);
  end

  // one walker step for bytes past the header
  assign stepped = walk_step(cur, in_byte);

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    gif_match_next      = gif_match;
    marker_next         = marker;
    segment_length_next = segment_length;
    skip_count_next     = skip_count;
    width_acc_next      = width_acc;
    height_acc_next     = height_acc;
    fire                = 1'b0;
    fire_kind           = KIND_NONE;
    fire_width          = width_acc;
    fire_height         = height_acc;

    if (phase == PH_HEAD) begin
      if (header_index == IDX_GIF_END) begin
        gif_match_next = (upcase(hdr[0]) == "G") && (upcase(hdr[1]) == "I") &&
                         (upcase(in_byte) == "F");
      end
      if (header_index >= IDX_LAST) begin
        if (gif_match) begin
          // little-endian dimensions straight from the header
          fire           = 1'b1;
          fire_kind      = KIND_GIF;
          fire_width     = {hdr[7], hdr[6]};
          fire_height    = {in_byte, hdr[8]};
          width_acc_next = fire_width;
          height_acc_next = fire_height;
        end else if (jfif_match) begin
          segment_length_next = app0_len;
          if (app0_len < MIN_SEG_LEN) begin
            fire = 1'b1;
          end else begin
            phase_next          = walked.phase;
            marker_next         = walked.marker;
            segment_length_next = walked.seglen;
            skip_count_next     = walked.skip;
            width_acc_next      = walked.width;
            height_acc_next     = walked.height;
            fire                = walked.fire;
            fire_kind           = walked.kind;
            fire_width          = walked.width;
            fire_height         = walked.height;
          end
        end else begin
          fire = 1'b1;
        end
      end else begin
        header_index_next = header_index + 4'd1;
      end
    end else if (phase != PH_DONE) begin
      phase_next          = stepped.phase;
      marker_next         = stepped.marker;
      segment_length_next = stepped.seglen;
      skip_count_next     = stepped.skip;
      width_acc_next      = stepped.width;
      height_acc_next     = stepped.height;
      fire                = stepped.fire;
      fire_kind           = stepped.kind;
      fire_width          = stepped.width;
      fire_height         = stepped.height;
    end

    if (fire) phase_next = PH_DONE;

    // end of file returns everything to the start state
    if (last_byte) begin
      phase_next          = PH_HEAD;
      header_index_next   = '0;
      gif_match_next      = 1'b0;
      marker_next         = '0;
      segment_length_next = '0;
      skip_count_next     = '0;
      width_acc_next      = '0;
      height_acc_next     = '0;
    end
  end

  // a result leaves on a settled file, or on an early end with none yet
  assign res = fire || (last_byte && (phase != PH_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD;
      header_index   <= '0;
      gif_match      <= 1'b0;
      marker         <= '0;
      segment_length <= '0;
      skip_count     <= '0;
      width_acc      <= '0;
      height_acc     <= '0;
    end else if (in_take) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      gif_match      <= gif_match_next;
      marker         <= marker_next;
      segment_length <= segment_length_next;
      skip_count     <= skip_count_next;
      width_acc      <= width_acc_next;
      height_acc     <= height_acc_next;
    end
  end

  // header byte store, bytes 0..8 (byte 9 is used as it arrives)
  always_ff @(posedge clk) begin
    if (in_take && (phase == PH_HEAD) && (header_index < IDX_LAST)) begin
      hdr[header_index] <= in_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res) begin
      kind   <= fire ? fire_kind : KIND_NONE;
      width  <= (fire && (fire_kind != KIND_NONE)) ? fire_width : '0;
      height <= (fire && (fire_kind != KIND_NONE)) ? fire_height : '0;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_NONE || kind == KIND_GIF || kind == KIND_JPEG))
    else $error("illegal result kind");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NONE) |-> (width == '0 && height == '0))
    else $error("unknown result with nonzero dimensions");

  a_hdr_idx: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEAD) |-> (header_index == IDX_LAST))
    else $error("left header phase before the tenth byte");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_file_restart: assert property (@(posedge clk) disable iff (rst)
    (in_take && last_byte) |=> (phase == PH_HEAD && header_index == '0))
    else $error("parser not restarted after last byte");

endmodule

>>> sim/tb_image_header_size_sniffer.sv
// testbench for the image header size sniffer: directed files, then random byte streams
`timescale 1ns / 1ps

module tb_image_header_size_sniffer;
  import ihss_pkg::*;

  // run limits: times in clock cycles, then a byte budget and a print cap
  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_BYTES = 1670;
  localparam int MAX_PRINTS   = 40;

  // one result word
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
  } dims_t;

  // one directed file: bytes written first-byte-leftmost, last_byte on the final one
  typedef struct {
    int           n;
    logic [255:0] data;
    bit           typed;
    dims_t        want;
  } file_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_byte = '0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KindW-1:0]  kind;
  logic [DimW-1:0]   width;
  logic [DimW-1:0]   height;

  // expectation that travels with the word on the input side (directed rows)
  bit                row_typed = 1'b0;
  dims_t             row_exp = '0;

  // sniffer shadow state
  logic [PhaseW-1:0] snf_phase;
  logic [IdxW-1:0]   snf_idx;
  bit                gif_hit;
  bit                jfif_hit;
  logic [DimW-1:0]   seg_len;
  logic [DimW-1:0]   skip_left;
  logic [DimW-1:0]   w_acc;
  logic [DimW-1:0]   h_acc;
  bit                reported;
  logic [ByteW-1:0]  hdr_seen [10];
  logic [ByteW-1:0]  marker;

  dims_t             expected_dims [$];
  file_row_t         dir_rows [$];
  logic [ByteW-1:0]  file_bytes [$];

  int                errors = 0;
  int                cycles_run;
  bit                src_calm = 1'b0;
  bit                sink_calm = 1'b0;
  bit                long_hold_req = 1'b0;

  // monitor scratch
  bit                mon_got;
  dims_t             mon_res;
  dims_t             mon_want;

  image_header_size_sniffer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .width     (width),
    .height    (height)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // ascii lower to upper, everything else passes through
  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] b);
    if (b >= "a" && b <= "z") return b - 8'd32;
    return b;
  endfunction

  task automatic clear_sniffer();
    snf_phase = PH_HEAD;
    snf_idx   = '0;
    gif_hit   = 1'b0;
    jfif_hit  = 1'b0;
    seg_len   = '0;
    skip_left = '0;
    w_acc     = '0;
    h_acc     = '0;
    reported  = 1'b0;
    marker    = '0;
    foreach (hdr_seen[i]) hdr_seen[i] = '0;
  endtask

  // one byte through the jpeg marker walk
  task automatic walk_marker(input logic [ByteW-1:0] b, inout bit fired,
                             inout logic [KindW-1:0] k);
    case (snf_phase)
      PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == '0) snf_phase = PH_MARK;
      end
      PH_MARK: begin
        marker    = b;
        snf_phase = PH_LHI;
      end
      PH_LHI: begin
        seg_len   = {b, 8'h00};
        snf_phase = PH_LLO;
      end
      PH_LLO: begin
        seg_len[7:0] = b;
        if (marker == SOF0 || marker == SOF1 || marker == SOF9) begin
          snf_phase = PH_PREC;
        end else if (seg_len < MIN_SEG_LEN) begin
          // segment too short to step over: malformed
          k     = KIND_NONE;
          fired = 1'b1;
        end else begin
          skip_left = seg_len - 16'd1;
          snf_phase = PH_SKIP;
        end
      end
      PH_PREC: snf_phase = PH_HHI;
      PH_HHI: begin
        h_acc     = {b, 8'h00};
        snf_phase = PH_HLO;
      end
      PH_HLO: begin
        h_acc[7:0] = b;
        snf_phase  = PH_WHI;
      end
      PH_WHI: begin
        w_acc     = {b, 8'h00};
        snf_phase = PH_WLO;
      end
      PH_WLO: begin
        w_acc[7:0] = b;
        k          = KIND_JPEG;
        fired      = 1'b1;
      end
      default: ;
    endcase
  endtask

  // one accepted input word; got is set when a result word is due
  task automatic sniff_byte(input logic [ByteW-1:0] b, input logic fin,
                            output bit got, output dims_t res);
    bit               fired;
    logic [KindW-1:0] k;
    logic [IdxW-1:0]  i;
    fired = 1'b0;
    k     = KIND_NONE;
    got   = 1'b0;
    res   = '0;
    if (snf_phase == PH_HEAD) begin
      hdr_seen[snf_idx] = b;
      if (snf_idx == IDX_GIF_END)
        gif_hit = fold_case(hdr_seen[0]) == "G" && fold_case(hdr_seen[1]) == "I" &&
                  fold_case(hdr_seen[2]) == "F";
      if (snf_idx >= IDX_LAST) begin
        jfif_hit = fold_case(hdr_seen[6]) == "J" && fold_case(hdr_seen[7]) == "F" &&
                   fold_case(hdr_seen[8]) == "I" && fold_case(hdr_seen[9]) == "F";
        if (gif_hit) begin
          // gif wins even if the jfif tag is also present
          w_acc = {hdr_seen[7], hdr_seen[6]};
          h_acc = {hdr_seen[9], hdr_seen[8]};
          k     = KIND_GIF;
          fired = 1'b1;
        end else if (jfif_hit) begin
          seg_len = {hdr_seen[4], hdr_seen[5]};
          if (seg_len < MIN_SEG_LEN) begin
            fired = 1'b1;
          end else begin
            // app0 may be short enough that the walk starts inside the header
            skip_left = seg_len - 16'd1;
            snf_phase = PH_SKIP;
            for (i = 4'd6; i < 4'd10 && !fired; i++) walk_marker(hdr_seen[i], fired, k);
          end
        end else begin
          fired = 1'b1;
        end
      end else begin
        snf_idx = snf_idx + 4'd1;
      end
    end else if (snf_phase != PH_DONE) begin
      walk_marker(b, fired, k);
    end

    if (fired) begin
      res.kind   = k;
      res.width  = (k != KIND_NONE) ? w_acc : '0;
      res.height = (k != KIND_NONE) ? h_acc : '0;
      reported   = 1'b1;
      snf_phase  = PH_DONE;
      got        = 1'b1;
    end

    // file end: an unreported file closes as unknown, then everything restarts
    if (fin) begin
      if (!reported) begin
        res = '{KIND_NONE, '0, '0};
        got = 1'b1;
      end
      clear_sniffer();
    end
  endtask

  initial clear_sniffer();

  // predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sniff_byte(in_byte, last_byte, mon_got, mon_res);
        if (mon_got) expected_dims.push_back(row_typed ? row_exp : mon_res);
      end
      if (out_valid && !out_stall) begin
        if (expected_dims.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d w %0d h %0d",
                                    kind, width, height));
        end else begin
          mon_want = expected_dims.pop_front();
          if (kind !== mon_want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", kind, mon_want.kind));
          if (width !== mon_want.width)
            report_mismatch($sformatf("width got %0d want %0d", width, mon_want.width));
          if (height !== mon_want.height)
            report_mismatch($sformatf("height got %0d want %0d", height, mon_want.height));
        end
      end
    end
  end

  // sink: random hold per result, calm stretches, and one long hold on request
  initial begin
    int n;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        // long hold, counted here, so the output register fills and input backs up
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        n = sink_calm ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
    end
  end

  // hard stop
  initial begin
    cycles_run = 0;
    while (cycles_run < RUN_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("timeout after %0d cycles", cycles_run);
    $display("Regression FAIL");
    $finish;
  end

  // offer one word after a random gap; returns at the falling edge after acceptance
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin,
                           input bit typed, input dims_t want);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      // idle: payload is junk while valid is low
      in_valid  <= 1'b0;
      in_byte   <= ByteW'($urandom);
      last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= fin;
    row_typed <= typed;
    row_exp   <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file(input bit typed, input dims_t want);
    int i;
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1, typed, want);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_dims.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input int n, input logic [255:0] data, input bit typed,
                         input logic [KindW-1:0] k, input logic [DimW-1:0] w,
                         input logic [DimW-1:0] h);
    file_row_t r;
    r.n    = n;
    r.data = data;
    r.typed = typed;
    r.want = '{k, w, h};
    dir_rows.push_back(r);
  endtask

  function automatic logic [ByteW-1:0] mix_case(input logic [ByteW-1:0] c);
    return $urandom_range(0, 1) ? c : c + 8'd32;
  endfunction

  function automatic logic [DimW-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DimW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ByteW-1:0] non_sof_marker();
    logic [ByteW-1:0] m;
    do m = ByteW'($urandom); while (m == SOF0 || m == SOF1 || m == SOF9);
    return m;
  endfunction

  task automatic make_gif();
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    file_bytes.delete();
    file_bytes.push_back(mix_case("G"));
    file_bytes.push_back(mix_case("I"));
    file_bytes.push_back(mix_case("F"));
    repeat (3) file_bytes.push_back(ByteW'($urandom));
    w = rand_dim();
    h = rand_dim();
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endtask

  // well-formed jfif walk with random segments; a few short lengths
  task automatic make_jfif();
    int              app_len;
    int              nseg;
    int              n;
    int              j;
    int              s;
    logic [DimW-1:0] lv;
    logic [DimW-1:0] v;
    file_bytes.delete();
    if ($urandom_range(0, 3) != 0) begin
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'hD8);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'hE0);
    end else begin
      repeat (4) file_bytes.push_back(ByteW'($urandom));
    end
    app_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(4, 12);
    lv = DimW'(app_len);
    file_bytes.push_back(lv[15:8]);
    file_bytes.push_back(lv[7:0]);
    file_bytes.push_back(mix_case("J"));
    file_bytes.push_back(mix_case("F"));
    file_bytes.push_back(mix_case("I"));
    file_bytes.push_back(mix_case("F"));
    if (app_len < 2) return;
    // rest of app0; its last byte is the marker prefix, mostly 0xFF
    for (j = 0; j < app_len - 5; j++)
      file_bytes.push_back((j == app_len - 6 && $urandom_range(0, 3) != 0) ? 8'hFF :
                           ByteW'($urandom));
    nseg = $urandom_range(0, 3);
    // app0 of 4 puts the first marker on the last tag byte
    if (app_len == 4 && nseg == 0) nseg = 1;
    for (s = 0; s < nseg; s++) begin
      if (!(s == 0 && app_len == 4)) file_bytes.push_back(non_sof_marker());
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      lv = DimW'(n);
      file_bytes.push_back(lv[15:8]);
      file_bytes.push_back(lv[7:0]);
      if (n < 2) return;
      for (j = 0; j < n - 1; j++)
        file_bytes.push_back((j == n - 2 && $urandom_range(0, 3) != 0) ? 8'hFF :
                             ByteW'($urandom));
    end
    case ($urandom_range(0, 2))
      0: file_bytes.push_back(SOF0);
      1: file_bytes.push_back(SOF1);
      default: file_bytes.push_back(SOF9);
    endcase
    repeat (3) file_bytes.push_back(ByteW'($urandom));
    v = rand_dim();
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[7:0]);
    v = rand_dim();
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[7:0]);
  endtask

  task automatic make_noise();
    repeat ($urandom_range(1, 14)) file_bytes.push_back(ByteW'($urandom));
  endtask

  initial begin
    int       r;
    int       i;
    int       cut;
    int       bytes_sent;
    int       files_done;
    int       waited;
    dims_t    none_d;

    none_d = '{KIND_NONE, '0, '0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed files
    add_row(1, 256'hFF, 1'b1, KIND_NONE, 16'd0, 16'd0);                  // one-byte file
    add_row(10, 256'h0, 1'b1, KIND_NONE, 16'd0, 16'd0);                  // no signature
    add_row(10, 256'h474946383961FFFFFFFF, 1'b1, KIND_GIF, 16'hFFFF, 16'hFFFF);
    // mixed-case gif, trailing bytes ignored after the result
    add_row(13, 256'h674966383761_12345678_AABBCC, 1'b1, KIND_GIF, 16'h3412, 16'h7856);
    add_row(10, 256'h474946_000005_4A464946, 1'b0, KIND_NONE, 16'd0, 16'd0); // gif and jfif
    add_row(10, 256'hFFD8FFE000014A464946, 1'b1, KIND_NONE, 16'd0, 16'd0); // app0 length 1
    // sof0 with a zero segment length, which is never looked at
    add_row(18, 256'hFFD8FFE000054A464946C0000008FFFFFFFF, 1'b1, KIND_JPEG, 16'hFFFF,
            16'hFFFF);
    add_row(15, 256'hFFD8FFE000054A464946E1000100FF, 1'b1, KIND_NONE, 16'd0,
            16'd0);                                                      // short segment
    add_row(18, 256'hFFD8FFE000054A464946C90011080010_0020, 1'b1, KIND_JPEG, 16'h0020,
            16'h0010);
    // mixed-case tag, zero marker prefix, one app1 segment then sof1
    add_row(24, 256'hFFD8FFE000076A466946_5A00E10002FF_C10011080001_0002, 1'b0, KIND_NONE,
            16'd0, 16'd0);
    // app0 of 4: the first marker is the last tag byte
    add_row(21, 256'hFFD8FFE000044A464946_0002FF_C000110801E0_0280, 1'b0, KIND_NONE,
            16'd0, 16'd0);
    add_row(6, 256'h474946383961, 1'b1, KIND_NONE, 16'd0, 16'd0);         // gif cut short
    add_row(14, 256'hFFD8FFE000054A464946C0001108, 1'b1, KIND_NONE, 16'd0,
            16'd0);                                                      // jfif cut short
    add_row(10, 256'hC7C9C600000000000000, 1'b1, KIND_NONE, 16'd0, 16'd0); // high-bit letters

    foreach (dir_rows[k]) begin
      file_bytes.delete();
      for (i = 0; i < dir_rows[k].n; i++)
        file_bytes.push_back(dir_rows[k].data[8*(dir_rows[k].n-1-i) +: 8]);
      src_calm = ($urandom_range(0, 3) == 0);
      send_file(dir_rows[k].typed, dir_rows[k].want);
    end

    // random files: mostly well-formed, some noise and cut-off files
    bytes_sent = 0;
    files_done = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      src_calm = ($urandom_range(0, 4) == 0);
      if (files_done == 40) begin
        long_hold_req = 1'b1;
        src_calm = 1'b1;
      end
      if (files_done == 60) pause_until_drained();
      file_bytes.delete();
      r = $urandom_range(0, 9);
      if (r < 3) make_gif();
      else if (r < 8) make_jfif();
      else make_noise();
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else begin
        repeat ($urandom_range(0, 3)) file_bytes.push_back(ByteW'($urandom));
      end
      send_file(1'b0, none_d);
      bytes_sent += file_bytes.size();
      files_done++;
    end
    in_valid <= 1'b0;

    // drain, then a short tail for anything spurious
    waited = 0;
    while (expected_dims.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_dims.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_dims.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
